### sv/mmpc_pkg.sv
`default_nettype none

package mmpc_pkg;

    localparam int EXP_BITS_DEF = 32;
    localparam int EXP_IN_W     = 32;
    localparam int IN_TDATA_W   = 32;
    localparam int DATA_W       = 14;
    localparam int OUT_TDATA_W  = 16;

    // Sum of three reduced products fits in SUM_W bits
    localparam int SUM_W       = 29;
    localparam int RECIP_SHIFT = 42;
    localparam int RECIP_W     = 29;
    localparam int QM_W        = SUM_W + RECIP_W;
    localparam int Q_W         = 15;
    localparam int REM_W       = DATA_W + 1;
    localparam int IDX_W       = 4;
    localparam int RC_W        = 2;
    localparam int ENTRIES     = 9;

    localparam logic [DATA_W-1:0]  MOD_VAL = DATA_W'(10007);
    localparam logic [RECIP_W-1:0] RECIP   =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd10007);

    localparam logic [IDX_W-1:0] INIT_LAST = IDX_W'(ENTRIES - 1);
    localparam logic [RC_W-1:0]  RC_LAST   = RC_W'(2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_BIT,
        ST_MUL,
        ST_SQR,
        ST_FIN_RD,
        ST_FIN_OUT
    } state_t;

    typedef struct packed {
        logic             load_exp;
        logic             shift_exp;
        logic             init_we;
        logic [IDX_W-1:0] init_idx;
        logic             mode_sqr;
        logic             rd_en;
        logic [RC_W-1:0]  idx_i;
        logic [RC_W-1:0]  idx_j;
        logic [RC_W-1:0]  idx_k;
        logic             mac_first;
        logic             mac_add;
        logic             red1;
        logic             red2;
        logic             res_we;
        logic             flip_acc;
        logic             flip_base;
        logic             out_load;
    } cmd_t;

    typedef struct packed {
        logic exp_zero;
        logic exp_lsb;
        logic exp_rest_zero;
        logic out_free;
    } sts_t;

    function automatic logic [DATA_W-1:0] ident_entry(input logic [IDX_W-1:0] idx);
        logic [DATA_W-1:0] v;
        case (idx)
            4'd0, 4'd4, 4'd8: v = DATA_W'(1);
            default:          v = '0;
        endcase
        return v;
    endfunction

    // Transition matrix rows: [2 1 0] [2 2 2] [0 1 2]
    function automatic logic [DATA_W-1:0] trans_entry(input logic [IDX_W-1:0] idx);
        logic [DATA_W-1:0] v;
        case (idx)
            4'd0, 4'd3, 4'd4, 4'd5, 4'd8: v = DATA_W'(2);
            4'd1, 4'd7:                   v = DATA_W'(1);
            default:                      v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### sv/mmpc_ctrl.sv
`default_nettype none

module mmpc_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire mmpc_pkg::sts_t  sts,
    output mmpc_pkg::cmd_t       cmd
);

    localparam logic [2:0] PH_LAST_RD = 3'd2;
    localparam logic [2:0] PH_FIRST   = 3'd1;
    localparam logic [2:0] PH_ADD0    = 3'd2;
    localparam logic [2:0] PH_ADD1    = 3'd3;
    localparam logic [2:0] PH_RED1    = 3'd4;
    localparam logic [2:0] PH_RED2    = 3'd5;
    localparam logic [2:0] PH_WRITE   = 3'd6;

    mmpc_pkg::state_t state_reg, state_next;
    logic [2:0]                     phase_reg, phase_next;
    logic [mmpc_pkg::RC_W-1:0]      i_reg, i_next;
    logic [mmpc_pkg::RC_W-1:0]      j_reg, j_next;
    logic [mmpc_pkg::IDX_W-1:0]     idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mmpc_pkg::ST_IDLE;
            phase_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        idx_next     = idx_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.init_idx = idx_reg;
        cmd.idx_i    = i_reg;
        cmd.idx_j    = j_reg;
        cmd.idx_k    = phase_reg[mmpc_pkg::RC_W-1:0];
        cmd.mode_sqr = (state_reg == mmpc_pkg::ST_SQR);

        case (state_reg)
            mmpc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_exp = 1'b1;
                    idx_next     = '0;
                    state_next   = mmpc_pkg::ST_INIT;
                end
            end

            mmpc_pkg::ST_INIT:
            begin
                // load identity into acc and the transition matrix into base
                cmd.init_we = 1'b1;
                if (idx_reg == mmpc_pkg::INIT_LAST)
                    state_next = mmpc_pkg::ST_BIT;
                else
                    idx_next = idx_reg + 1'b1;
            end

            mmpc_pkg::ST_BIT:
            begin
                phase_next = '0;
                i_next     = '0;
                j_next     = '0;
                if (sts.exp_zero)
                    state_next = mmpc_pkg::ST_FIN_RD;
                else if (sts.exp_lsb)
                    state_next = mmpc_pkg::ST_MUL;
                else
                    state_next = mmpc_pkg::ST_SQR;
            end

            mmpc_pkg::ST_MUL, mmpc_pkg::ST_SQR:
            begin
                cmd.rd_en     = (phase_reg <= PH_LAST_RD);
                cmd.mac_first = (phase_reg == PH_FIRST);
                cmd.mac_add   = (phase_reg == PH_ADD0) || (phase_reg == PH_ADD1);
                cmd.red1      = (phase_reg == PH_RED1);
                cmd.red2      = (phase_reg == PH_RED2);
                if (phase_reg == PH_WRITE)
                begin
                    cmd.res_we = 1'b1;
                    phase_next = '0;
                    if (j_reg == mmpc_pkg::RC_LAST)
                    begin
                        j_next = '0;
                        if (i_reg == mmpc_pkg::RC_LAST)
                        begin
                            i_next = '0;
                            if (state_reg == mmpc_pkg::ST_MUL)
                            begin
                                cmd.flip_acc = 1'b1;
                                // skip the square when no higher bit remains
                                if (sts.exp_rest_zero)
                                    state_next = mmpc_pkg::ST_FIN_RD;
                                else
                                    state_next = mmpc_pkg::ST_SQR;
                            end
                            else
                            begin
                                cmd.flip_base = 1'b1;
                                cmd.shift_exp = 1'b1;
                                state_next    = mmpc_pkg::ST_BIT;
                            end
                        end
                        else
                            i_next = i_reg + 1'b1;
                    end
                    else
                        j_next = j_reg + 1'b1;
                end
                else
                    phase_next = phase_reg + 1'b1;
            end

            mmpc_pkg::ST_FIN_RD:
            begin
                // fetch acc entry (2,2)
                cmd.rd_en    = 1'b1;
                cmd.mode_sqr = 1'b0;
                cmd.idx_i    = mmpc_pkg::RC_LAST;
                cmd.idx_k    = mmpc_pkg::RC_LAST;
                state_next   = mmpc_pkg::ST_FIN_OUT;
            end

            mmpc_pkg::ST_FIN_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = mmpc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mmpc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/mmpc_dp.sv
`default_nettype none

module mmpc_dp #(
    parameter int EXP_BITS = mmpc_pkg::EXP_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [mmpc_pkg::EXP_IN_W-1:0]       exponent,
    input  wire mmpc_pkg::cmd_t                      cmd,
    output mmpc_pkg::sts_t                           sts,
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output logic [mmpc_pkg::DATA_W-1:0]              count_mod
);

    localparam int DW = mmpc_pkg::DATA_W;
    localparam int AW = mmpc_pkg::IDX_W;

    // two banks each: one holds the current matrix, the other takes the product
    logic [DW-1:0] acc_mem  [2][mmpc_pkg::ENTRIES];
    logic [DW-1:0] base_mem [2][mmpc_pkg::ENTRIES];

    logic                          acc_bank_reg, acc_bank_next;
    logic                          base_bank_reg, base_bank_next;
    logic                          out_valid_reg, out_valid_next;
    logic [DW-1:0]                 out_data_reg;
    logic [EXP_BITS-1:0]           exp_reg;
    logic [DW-1:0]                 acc_rd_reg;
    logic [DW-1:0]                 base_rda_reg;
    logic [DW-1:0]                 base_rdb_reg;
    logic [mmpc_pkg::SUM_W-1:0]    sum_reg;
    logic [mmpc_pkg::QM_W-1:0]     qm_reg;
    logic [mmpc_pkg::SUM_W-1:0]    qp_reg;

    logic [AW-1:0]                 x_addr, y_addr, w_addr;
    logic [DW-1:0]                 x_op;
    logic [2*DW-1:0]               prod;
    logic [mmpc_pkg::Q_W-1:0]      q_est;
    logic [mmpc_pkg::SUM_W-1:0]    diff;
    logic [mmpc_pkg::REM_W-1:0]    rem;
    logic [DW-1:0]                 res_val;

    assign x_addr = AW'({2'b00, cmd.idx_i} * 4'd3 + {2'b00, cmd.idx_k});
    assign y_addr = AW'({2'b00, cmd.idx_k} * 4'd3 + {2'b00, cmd.idx_j});
    assign w_addr = AW'({2'b00, cmd.idx_i} * 4'd3 + {2'b00, cmd.idx_j});

    assign x_op = cmd.mode_sqr ? base_rdb_reg : acc_rd_reg;
    assign prod = x_op * base_rda_reg;

    // floor reciprocal leaves the remainder below twice the modulus
    assign q_est   = qm_reg[mmpc_pkg::RECIP_SHIFT +: mmpc_pkg::Q_W];
    assign diff    = sum_reg - qp_reg;
    assign rem     = diff[mmpc_pkg::REM_W-1:0];
    assign res_val = (rem >= {1'b0, mmpc_pkg::MOD_VAL})
                   ? DW'(rem - {1'b0, mmpc_pkg::MOD_VAL}) : rem[DW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.init_we)
            acc_mem[acc_bank_reg][cmd.init_idx] <= mmpc_pkg::ident_entry(cmd.init_idx);
        else if (cmd.res_we && !cmd.mode_sqr)
            acc_mem[!acc_bank_reg][w_addr] <= res_val;
        if (cmd.rd_en)
            acc_rd_reg <= acc_mem[acc_bank_reg][x_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_we)
            base_mem[base_bank_reg][cmd.init_idx] <= mmpc_pkg::trans_entry(cmd.init_idx);
        else if (cmd.res_we && cmd.mode_sqr)
            base_mem[!base_bank_reg][w_addr] <= res_val;
        if (cmd.rd_en)
        begin
            base_rda_reg <= base_mem[base_bank_reg][y_addr];
            base_rdb_reg <= base_mem[base_bank_reg][x_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_exp)
            exp_reg <= EXP_BITS'(exponent);
        else if (cmd.shift_exp)
            exp_reg <= exp_reg >> 1;
        if (cmd.mac_first)
            sum_reg <= mmpc_pkg::SUM_W'(prod);
        else if (cmd.mac_add)
            sum_reg <= sum_reg + mmpc_pkg::SUM_W'(prod);
        if (cmd.red1)
            qm_reg <= sum_reg * mmpc_pkg::RECIP;
        if (cmd.red2)
            qp_reg <= q_est * mmpc_pkg::MOD_VAL;
        if (cmd.out_load)
            out_data_reg <= acc_rd_reg;
    end

    always_comb
    begin
        acc_bank_next  = acc_bank_reg ^ cmd.flip_acc;
        base_bank_next = base_bank_reg ^ cmd.flip_base;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_bank_reg  <= 1'b0;
            base_bank_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_bank_reg  <= acc_bank_next;
            base_bank_reg <= base_bank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign sts.exp_zero      = (exp_reg == '0);
    assign sts.exp_lsb       = exp_reg[0];
    assign sts.exp_rest_zero = ((exp_reg >> 1) == '0);
    assign sts.out_free      = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign count_mod = out_data_reg;

endmodule

`default_nettype wire

### sv/modular_matrix_power_count_top.sv
// Raises the fixed 3x3 matrix [2 1 0; 2 2 2; 0 1 2] to the power given on the
// slave stream, modulo 10007, and returns entry (2,2) of the result on the
// master stream: one output word for every input word.
// One exponent is processed at a time; s_axis_tready is high only while the
// block is idle. A finished result waits in an output register, so the next
// exponent is taken while that word is still stalled by m_axis_tready low;
// if that exponent finishes before the word leaves, the input stays blocked.
// Steps: the start matrices are loaded entry by entry, then each exponent bit
// is tested in ST_BIT, and each 3x3 modular matrix product is computed entry
// by entry (9 entries, each read, multiplied and summed, reduced in two steps
// and written) on the one 14x14 multiply-accumulate and the reciprocal
// reduction; acc entry (2,2) is then read out. The next exponent can be taken
// at the first edge at which the result can be taken. The square after the
// top set bit is skipped.
// Reset clears the controller and the output valid; the matrix memories
// are reloaded at the start of every exponent.
`default_nettype none

module modular_matrix_power_count_top #(
    parameter int EXP_BITS = mmpc_pkg::EXP_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [31:0] exponent
    input  wire logic [mmpc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [13:0] count_mod, [15:14] zero
    output logic [mmpc_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);

    mmpc_pkg::cmd_t                  cmd;
    mmpc_pkg::sts_t                  sts;
    logic [mmpc_pkg::DATA_W-1:0]     count_mod;

    mmpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mmpc_dp #(
        .EXP_BITS (EXP_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .exponent  (s_axis_tdata[mmpc_pkg::EXP_IN_W-1:0]),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .count_mod (count_mod)
    );

    assign m_axis_tdata = mmpc_pkg::OUT_TDATA_W'(count_mod);

endmodule

`default_nettype wire
